### src/ifd_pkg.sv
// shared types and constants of the sensor-link frame deframer
// no dependencies; imported by ifd_regs, ifd_match and the top level
package ifd_pkg;

	// frame geometry
	localparam int FrameBytesDef = 11;
	localparam int FrameBytesMin = 11;
	localparam int FrameBytesMax = 16;

	// configuration port geometry
	localparam int AddrW = 5;
	localparam int DataW = 32;
	localparam int RegIdxW = 3;

	// register indexes
	localparam logic [RegIdxW-1:0] REG_HEADER = 3'd0;
	localparam logic [RegIdxW-1:0] REG_ACCEL = 3'd1;
	localparam logic [RegIdxW-1:0] REG_GYRO = 3'd2;
	localparam logic [RegIdxW-1:0] REG_ANGLE = 3'd3;
	localparam logic [RegIdxW-1:0] REG_MAG = 3'd4;
	localparam logic [RegIdxW-1:0] REG_QUAT = 3'd5;

	// register reset values
	localparam logic [7:0] RST_HEADER = 8'h55;
	localparam logic [7:0] RST_ACCEL = 8'h51;
	localparam logic [7:0] RST_GYRO = 8'h52;
	localparam logic [7:0] RST_ANGLE = 8'h53;
	localparam logic [7:0] RST_MAG = 8'h54;
	localparam logic [7:0] RST_QUAT = 8'h59;

	// frame kinds
	localparam logic [2:0] KIND_ACCEL = 3'd0;
	localparam logic [2:0] KIND_GYRO = 3'd1;
	localparam logic [2:0] KIND_ANGLE = 3'd2;
	localparam logic [2:0] KIND_MAG = 3'd3;
	localparam logic [2:0] KIND_QUAT = 3'd4;

	// configuration seen by the datapath
	typedef struct packed {
		logic [7:0] header;
		logic [7:0] accel;
		logic [7:0] gyro;
		logic [7:0] angle;
		logic [7:0] mag;
		logic [7:0] quat;
	} cfg_t;

	// type lookup result
	typedef struct packed {
		logic       hit;
		logic [2:0] kind;
	} type_match_t;

endpackage

### src/ifd_cell.sv
// one byte cell of the sliding frame window
// depends on nothing; chained by the top level, each cell feeding its older neighbor
module ifd_cell (
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	// take the newer neighbor's byte on every accepted request
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

### src/ifd_match.sv
// type byte lookup against the five configured frame codes
// depends on ifd_pkg
module ifd_match import ifd_pkg::*; (
	input  cfg_t        cfg,
	input  logic [7:0]  type_byte,
	output type_match_t res
);

	// first match in accel, gyro, angle, magnetic, quaternion order wins
	always_comb begin
		res.hit = 1'b1;
		res.kind = KIND_ACCEL;
		priority if (type_byte == cfg.accel) begin
			res.kind = KIND_ACCEL;
		end else if (type_byte == cfg.gyro) begin
			res.kind = KIND_GYRO;
		end else if (type_byte == cfg.angle) begin
			res.kind = KIND_ANGLE;
		end else if (type_byte == cfg.mag) begin
			res.kind = KIND_MAG;
		end else if (type_byte == cfg.quat) begin
			res.kind = KIND_QUAT;
		end else begin
			res.hit = 1'b0;
		end
	end

endmodule

### src/ifd_regs.sv
// configuration registers behind the APB-style port
// depends on ifd_pkg
module ifd_regs import ifd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t               cfg_q;
	logic               wr_en;
	logic [RegIdxW-1:0] reg_idx;
	logic [7:0]         rd_byte;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[AddrW-1:2];

	// register writes, low byte kept, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header <= RST_HEADER;
			cfg_q.accel <= RST_ACCEL;
			cfg_q.gyro <= RST_GYRO;
			cfg_q.angle <= RST_ANGLE;
			cfg_q.mag <= RST_MAG;
			cfg_q.quat <= RST_QUAT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HEADER: cfg_q.header <= pwdata[7:0];
				REG_ACCEL: cfg_q.accel <= pwdata[7:0];
				REG_GYRO: cfg_q.gyro <= pwdata[7:0];
				REG_ANGLE: cfg_q.angle <= pwdata[7:0];
				REG_MAG: cfg_q.mag <= pwdata[7:0];
				REG_QUAT: cfg_q.quat <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_HEADER: rd_byte = cfg_q.header;
			REG_ACCEL: rd_byte = cfg_q.accel;
			REG_GYRO: rd_byte = cfg_q.gyro;
			REG_ANGLE: rd_byte = cfg_q.angle;
			REG_MAG: rd_byte = cfg_q.mag;
			REG_QUAT: rd_byte = cfg_q.quat;
			default: rd_byte = 8'd0;
		endcase
	end

	assign prdata = {{(DataW-8){1'b0}}, rd_byte};
	assign cfg = cfg_q;

endmodule

### src/imu_frame_deframer.sv
// top level of the sensor-link frame deframer
// depends on ifd_pkg, ifd_regs, ifd_cell and ifd_match
//
// Usage: received link bytes enter on the input channel (in_valid, in_stall,
// rx_byte), one byte per request. A row of byte cells holds the last
// FRAME_BYTES bytes and shifts by one cell per accepted byte, so every byte
// position is tried as a frame start. A running 8-bit sum of all window bytes
// but the newest is updated as bytes enter and leave. A frame is reported
// when the window is full, its oldest byte equals the header register, the
// running sum equals the newest byte and the type byte matches a code register.
// Results (kind, word0..word3, raw little-endian signed words) leave on the
// output channel (out_valid, out_stall) from an output register.
// The result is registered as the closing checksum byte is accepted.
// Throughput: one byte per cycle while in_stall is low, set by the cell shift
// and running-sum update. When the receiver stalls with a result waiting,
// in_stall goes high until that result is taken. Reset clears the fill count,
// the running sum and the output valid, and loads the register defaults;
// a fresh window of FRAME_BYTES bytes is needed before the first frame.
module imu_frame_deframer import ifd_pkg::*; #(
	parameter int FRAME_BYTES = FrameBytesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [AddrW-1:0]   paddr,
	input  logic [DataW-1:0]   pwdata,
	output logic [DataW-1:0]   prdata,
	output logic               pready,
	// byte input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	// frame output
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic signed [15:0] word0,
	output logic signed [15:0] word1,
	output logic signed [15:0] word2,
	output logic signed [15:0] word3
);

	localparam int CntW = $clog2(FRAME_BYTES + 1);

	cfg_t              cfg;
	type_match_t       tmatch;
	logic [7:0]        win [FRAME_BYTES];
	logic              in_accept;
	logic [CntW-1:0]   fill_q;
	logic [7:0]        sum_q;
	logic [7:0]        sum_next;
	logic [7:0]        leave_byte;
	logic [7:0]        enter_byte;
	logic              full_next;
	logic              frame_hit;
	logic              out_valid_q;
	logic [2:0]        kind_q;
	logic [15:0]       word0_q;
	logic [15:0]       word1_q;
	logic [15:0]       word2_q;
	logic [15:0]       word3_q;

	ifd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: hold input only while a result waits on a stalled receiver
	assign in_stall = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	// row of byte cells, oldest at index 0, newest fed from rx_byte
	for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
		logic [7:0] cell_d;
		if (i == FRAME_BYTES - 1) begin : g_last
			assign cell_d = rx_byte;
		end else begin : g_mid
			assign cell_d = win[i+1];
		end
		ifd_cell u_cell (
			.clk      (clk),
			.shift_en (in_accept),
			.d        (cell_d),
			.q        (win[i])
		);
	end

	// running sum: oldest byte leaves, previous newest byte joins
	assign leave_byte = (fill_q == CntW'(FRAME_BYTES)) ? win[0] : 8'd0;
	assign enter_byte = (fill_q != '0) ? win[FRAME_BYTES-1] : 8'd0;
	assign sum_next = sum_q - leave_byte + enter_byte;
	assign full_next = (fill_q >= CntW'(FRAME_BYTES - 1));

	// type lookup on the byte that becomes the frame's second byte
	ifd_match u_match (
		.cfg       (cfg),
		.type_byte (win[2]),
		.res       (tmatch)
	);

	// frame check on the window as it stands after this byte
	assign frame_hit = full_next & (win[1] == cfg.header) & (sum_next == rx_byte) & tmatch.hit;

	// fill count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q <= 8'd0;
		end else if (in_accept) begin
			sum_q <= sum_next;
			if (fill_q != CntW'(FRAME_BYTES)) begin
				fill_q <= fill_q + CntW'(1);
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept && frame_hit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, little-endian words from frame bytes 2..9
	always_ff @(posedge clk) begin
		if (in_accept && frame_hit) begin
			kind_q <= tmatch.kind;
			word0_q <= {win[4], win[3]};
			word1_q <= {win[6], win[5]};
			word2_q <= {win[8], win[7]};
			word3_q <= {win[10], win[9]};
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign word0 = word0_q;
	assign word1 = word1_q;
	assign word2 = word2_q;
	assign word3 = word3_q;

endmodule

### tb/tb.sv
// testbench of the sensor-link frame deframer: byte stream in, decoded frames out
// depends on ifd_pkg and imu_frame_deframer; scoreboard class and bus tasks live here
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ifd_pkg::*;

	localparam int FrameLen = FrameBytesDef;
	localparam int SegBytes = 265;

	// register index with no register behind it
	localparam logic [RegIdxW-1:0] REG_UNMAPPED = 3'd6;

	// one decoded frame as seen on the output channel
	typedef struct {
		logic [2:0]         kind;
		logic signed [15:0] word [4];
	} frame_t;

	// sliding-window decoder with a queue of frames still to come out
	class ifd_frame_scoreboard;
		cfg_t       regs;
		logic [7:0] window [FrameLen];
		int         fill;
		frame_t     pending [$];
		int         errors;
		int         frames_ok;
		int         per_kind [5];

		function new();
			regs = '{header: RST_HEADER, accel: RST_ACCEL, gyro: RST_GYRO,
				angle: RST_ANGLE, mag: RST_MAG, quat: RST_QUAT};
			fill = 0;
			errors = 0;
			frames_ok = 0;
			foreach (per_kind[i]) per_kind[i] = 0;
			foreach (window[i]) window[i] = 8'h00;
		endfunction

		function void set_reg(logic [RegIdxW-1:0] idx, logic [7:0] v);
			case (idx)
				REG_HEADER: regs.header = v;
				REG_ACCEL: regs.accel = v;
				REG_GYRO: regs.gyro = v;
				REG_ANGLE: regs.angle = v;
				REG_MAG: regs.mag = v;
				REG_QUAT: regs.quat = v;
				default: ;
			endcase
		endfunction

		function logic [7:0] reg_value(logic [RegIdxW-1:0] idx);
			case (idx)
				REG_HEADER: return regs.header;
				REG_ACCEL: return regs.accel;
				REG_GYRO: return regs.gyro;
				REG_ANGLE: return regs.angle;
				REG_MAG: return regs.mag;
				default: return regs.quat;
			endcase
		endfunction

		// shift one accepted byte in and queue the frame it closes, if any
		function void note_byte(logic [7:0] b);
			logic [7:0] csum;
			logic [7:0] tcode;
			frame_t     fr;
			for (int i = 0; i < FrameLen - 1; i++) window[i] = window[i+1];
			window[FrameLen-1] = b;
			if (fill < FrameLen) fill++;
			if (fill < FrameLen || window[0] != regs.header) return;
			csum = 8'h00;
			for (int i = 0; i < FrameLen - 1; i++) csum += window[i];
			if (csum != window[FrameLen-1]) return;
			// first matching code wins
			tcode = window[1];
			if (tcode == regs.accel) fr.kind = KIND_ACCEL;
			else if (tcode == regs.gyro) fr.kind = KIND_GYRO;
			else if (tcode == regs.angle) fr.kind = KIND_ANGLE;
			else if (tcode == regs.mag) fr.kind = KIND_MAG;
			else if (tcode == regs.quat) fr.kind = KIND_QUAT;
			else return;
			for (int i = 0; i < 4; i++) fr.word[i] = {window[3+2*i], window[2+2*i]};
			pending.push_back(fr);
		endfunction

		// compare one accepted result with the oldest queued frame
		function void check_frame(frame_t got);
			frame_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected frame: kind %0d words %h %h %h %h", $time,
					got.kind, got.word[0], got.word[1], got.word[2], got.word[3]);
				errors++;
				return;
			end
			want = pending.pop_front();
			frames_ok++;
			if (want.kind <= KIND_QUAT) per_kind[want.kind]++;
			if (got.kind !== want.kind) begin
				$display("%0t kind mismatch: expected %0d actual %0d", $time,
					want.kind, got.kind);
				errors++;
			end
			for (int i = 0; i < 4; i++) begin
				if (got.word[i] !== want.word[i]) begin
					$display("%0t word%0d mismatch: expected %h actual %h", $time, i,
						want.word[i], got.word[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [AddrW-1:0]     paddr = '0;
	logic [DataW-1:0]     pwdata = '0;
	logic [DataW-1:0]     prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           kind;
	logic signed [15:0]   word0, word1, word2, word3;

	ifd_frame_scoreboard sb;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  calm = 1'b0;
	int  bytes_sent = 0;
	int  reg_errors = 0;

	imu_frame_deframer u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.word0(word0), .word1(word1), .word2(word2), .word3(word3)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver backpressure
	always @(negedge clk) begin
		out_stall <= !calm && recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct;
	end

	// result monitor
	always @(posedge clk) begin
		frame_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind;
			got.word[0] = word0;
			got.word[1] = word1;
			got.word[2] = word2;
			got.word[3] = word3;
			sb.check_frame(got);
		end
	end

	// all tasks below start and end just after a falling edge

	// one byte request, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		if (bytes_sent % 48 == 0) calm = ($urandom_range(3) == 0);
		while (!calm && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// header, type, eight payload bytes and checksum plus an optional error
	task automatic send_frame(input logic [7:0] hdr, input logic [7:0] tcode,
			input logic [63:0] pay, input logic [7:0] sum_err);
		logic [7:0] csum;
		csum = hdr + tcode;
		send_byte(hdr);
		send_byte(tcode);
		for (int i = 0; i < 8; i++) begin
			csum += pay[8*i +: 8];
			send_byte(pay[8*i +: 8]);
		end
		send_byte(csum + sum_err);
	endtask

	// one write transfer, then the bus is left idle
	task automatic bus_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx <= REG_QUAT) sb.set_reg(idx, data[7:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// one read transfer, then the bus is left idle
	task automatic bus_check(input logic [RegIdxW-1:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== sb.reg_value(idx)) begin
			$display("%0t register %0d readback: expected %h actual %h", $time, idx,
				sb.reg_value(idx), prdata[7:0]);
			reg_errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// drain outstanding frames before touching the registers
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// load one register setting; upper data bits are junk the block must drop
	task automatic load_setting(input logic [7:0] v [6]);
		for (int i = 0; i < 6; i++)
			bus_write(RegIdxW'(i),
				{16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)), v[i]});
		// unmapped register index must be ignored
		bus_write(REG_UNMAPPED, $urandom);
		for (int i = 0; i < 6; i++) bus_check(RegIdxW'(i));
	endtask

	function automatic logic [7:0] unknown_code();
		logic [7:0] t;
		do t = 8'($urandom_range(255));
		while (t == sb.regs.accel || t == sb.regs.gyro || t == sb.regs.angle ||
			t == sb.regs.mag || t == sb.regs.quat);
		return t;
	endfunction

	function automatic logic [7:0] known_code();
		case ($urandom_range(4))
			0: return sb.regs.accel;
			1: return sb.regs.gyro;
			2: return sb.regs.angle;
			3: return sb.regs.mag;
			default: return sb.regs.quat;
		endcase
	endfunction

	// mostly good frames, plus unknown types, bad sums, bad headers, cut frames, noise
	task automatic run_segment(input int n_bytes);
		int stop_at;
		int r;
		logic [63:0] pay;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(99);
			pay = {$urandom, $urandom};
			if (r < 60)
				send_frame(sb.regs.header, known_code(), pay, 8'h00);
			else if (r < 70)
				send_frame(sb.regs.header, unknown_code(), pay, 8'h00);
			else if (r < 78)
				send_frame(sb.regs.header, known_code(), pay, 8'($urandom_range(1, 255)));
			else if (r < 85)
				send_frame(sb.regs.header ^ 8'($urandom_range(1, 255)), known_code(), pay,
					8'h00);
			else if (r < 92) begin
				send_byte(sb.regs.header);
				send_byte(known_code());
				repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(255)));
			end else
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
		end
	endtask

	// run watchdog
	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [7:0] v [6];
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extreme words on an accel frame, a quaternion frame, then noise
		send_idle_pct = 32;
		recv_idle_pct = 45;
		send_frame(RST_HEADER, RST_ACCEL, 64'hFFFF_0001_7FFF_8000, 8'h00);
		send_frame(RST_HEADER, RST_QUAT, 64'h8080_007F_0000_FFFF, 8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(RST_HEADER);
		run_segment(SegBytes);

		for (int seg = 1; seg < 6; seg++) begin
			settle();
			case (seg)
				1: v = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00};
				2: v = '{8'hFF, 8'h3C, 8'h3C, 8'h3C, 8'h3C, 8'h3C};
				3: begin
					foreach (v[i]) v[i] = 8'($urandom_range(255));
					v[3] = v[2];
					v[5] = v[4];
				end
				4: foreach (v[i]) v[i] = 8'($urandom_range(255));
				default: v = '{RST_HEADER, RST_ACCEL, RST_GYRO, RST_ANGLE, RST_MAG, RST_QUAT};
			endcase
			load_setting(v);
			send_idle_pct = (seg < 2) ? 32 : (seg < 4) ? 45 : 0;
			recv_idle_pct = (seg < 2) ? 45 : (seg < 4) ? 32 : 0;
			run_segment(SegBytes);
		end

		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d bytes under 6 register settings, %0d frames decoded",
			bytes_sent, sb.frames_ok);
		$display("by kind: accel %0d gyro %0d angle %0d mag %0d quat %0d",
			sb.per_kind[0], sb.per_kind[1], sb.per_kind[2], sb.per_kind[3], sb.per_kind[4]);
		if (sb.errors == 0 && reg_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

### files.f
src/ifd_pkg.sv
src/ifd_cell.sv
src/ifd_match.sv
src/ifd_regs.sv
src/imu_frame_deframer.sv
tb/tb.sv
